// ----- hdl/mcds_pkg.sv -----
// Shared types, constants and lookup functions for the month calendar sequencer.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package mcds_pkg;

  localparam int YEAR_W  = 15;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int WD_W    = 3;

  // Year offset: a whole 400-year cycle, keeps the year-before arithmetic positive
  localparam logic [15:0] CYCLE_YEARS = 16'd400;
  localparam logic [15:0] CENTURY     = 16'd100;
  localparam logic [11:0] WEEK_DAYS   = 12'd7;

  // Reciprocals: floor(x*5243 >> 19) == x/100 for x < 43699,
  // floor(x*4682 >> 15) == x/7 for x < 4096
  localparam logic [12:0] RECIP_100 = 13'd5243;
  localparam logic [12:0] RECIP_7   = 13'd4682;

  localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MON_MAR = 4'd3;
  localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MON_MAY = 4'd5;
  localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MON_JUL = 4'd7;
  localparam logic [MONTH_W-1:0] MON_AUG = 4'd8;
  localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MON_OCT = 4'd10;
  localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

  localparam logic [WD_W-1:0] WD_SATURDAY = 3'd0;
  localparam logic [WD_W-1:0] WD_FRIDAY   = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_REM,
    ST_SUM,
    ST_MOD,
    ST_WD,
    ST_EMIT
  } state_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic load;
    logic div;
    logic rem;
    logic sum;
    logic mod;
    logic wd;
    logic step;
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic month_ok;
    logic last_day;
  } sts_t;

  // floor(13*(m+1)/5) with Jan/Feb taken as months 13 and 14
  function automatic logic [5:0] month_offset(input logic [MONTH_W-1:0] m);
    logic [5:0] v;
    unique case (m)
      MON_JAN: v = 6'd36;
      MON_FEB: v = 6'd39;
      MON_MAR: v = 6'd10;
      MON_APR: v = 6'd13;
      MON_MAY: v = 6'd15;
      MON_JUN: v = 6'd18;
      MON_JUL: v = 6'd20;
      MON_AUG: v = 6'd23;
      MON_SEP: v = 6'd26;
      MON_OCT: v = 6'd28;
      MON_NOV: v = 6'd31;
      MON_DEC: v = 6'd33;
      default: v = 6'd0;
    endcase
    return v;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] v;
    unique case (m)
      MON_FEB:                            v = leap ? 5'd29 : 5'd28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: v = 5'd30;
      default:                            v = 5'd31;
    endcase
    return v;
  endfunction

endpackage

// ----- hdl/month_calendar_day_sequencer_top.sv -----
// An accepted item shows its first day after the load and the 5 setup steps.
// A new item is taken only after the last day of the one before; one day per
//   cycle while out_ready stays high. Setup goes through the shared datapath steps.
// A month of 0 or 13..15 is accepted and yields no item.
// Reset (rst_n low, synchronous) returns the controller to idle; data registers
//   are not reset.
`timescale 1ns / 1ps

module month_calendar_day_sequencer_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mcds_pkg::YEAR_W-1:0]   in_year,
  input  logic [mcds_pkg::MONTH_W-1:0]  in_month,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mcds_pkg::DAY_W-1:0]    out_day_number,
  output logic [mcds_pkg::WD_W-1:0]     out_weekday_column,
  output logic                          out_row_end,
  output logic                          out_last
);
  import mcds_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Controller: idle -> div -> rem -> sum -> mod -> wd -> emit (emit yields every day of the month)
  mcds_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath:
  //   div  - century by reciprocal multiply of (year + 400)
  //   rem  - remainder, year-before fix for Jan/Feb, leap test, month length
  //   sum  - Zeller sum
  //   mod  - quotient by 7 via reciprocal multiply
  //   wd   - weekday of the 1st, day counter preset
  //   step - next day, weekday wraps Friday -> Saturday
  mcds_dp u_dp (
    .clk                (clk),
    .cmd                (cmd),
    .sts                (sts),
    .in_year            (in_year),
    .in_month           (in_month),
    .out_day_number     (out_day_number),
    .out_weekday_column (out_weekday_column),
    .out_row_end        (out_row_end),
    .out_last           (out_last)
  );

endmodule

// ----- hdl/mcds_ctrl.sv -----
// Controller FSM: sequences the setup steps and the per-day emission.
// Depends on mcds_pkg.
`timescale 1ns / 1ps

module mcds_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  mcds_pkg::sts_t sts,
  output mcds_pkg::cmd_t cmd
);
  import mcds_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        // a bad month is taken and dropped
        if (in_valid && sts.month_ok) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div   = 1'b1;
        state_nxt = ST_REM;
      end
      ST_REM: begin
        cmd.rem   = 1'b1;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = ST_MOD;
      end
      ST_MOD: begin
        cmd.mod   = 1'b1;
        state_nxt = ST_WD;
      end
      ST_WD: begin
        cmd.wd    = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.step = 1'b1;
          if (sts.last_day) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ----- hdl/mcds_dp.sv -----
// Datapath: year split by 100, leap test, Zeller sum, mod 7, day/weekday counters.
// Depends on mcds_pkg.
`timescale 1ns / 1ps

module mcds_dp (
  input  logic                          clk,
  input  mcds_pkg::cmd_t                cmd,
  output mcds_pkg::sts_t                sts,
  input  logic [mcds_pkg::YEAR_W-1:0]   in_year,
  input  logic [mcds_pkg::MONTH_W-1:0]  in_month,
  output logic [mcds_pkg::DAY_W-1:0]    out_day_number,
  output logic [mcds_pkg::WD_W-1:0]     out_weekday_column,
  output logic                          out_row_end,
  output logic                          out_last
);
  import mcds_pkg::*;

  logic [MONTH_W-1:0] month_r,  month_nxt;
  logic [15:0]        yp_r,     yp_nxt;
  logic [8:0]         q_r,      q_nxt;
  logic [6:0]         k_r,      k_nxt;
  logic [8:0]         j_r,      j_nxt;
  logic [DAY_W-1:0]   len_r,    len_nxt;
  logic [11:0]        sum_r,    sum_nxt;
  logic [9:0]         q7_r,     q7_nxt;
  logic [DAY_W-1:0]   day_r,    day_nxt;
  logic [WD_W-1:0]    wd_r,     wd_nxt;

  logic [28:0] prod100;
  logic [15:0] rem100;
  logic [6:0]  r100;
  logic        early;
  logic        leap;
  logic [24:0] prod7;
  logic [11:0] rem7;

  always_comb begin
    prod100 = 29'(yp_r) * 29'(RECIP_100);
    rem100  = yp_r - 16'(16'(q_r) * CENTURY);
    r100    = rem100[6:0];
    early   = (month_r == MON_JAN) || (month_r == MON_FEB);
    // yp = year + 400, so divisibility by 4, 100 and 400 carries over
    leap    = (yp_r[1:0] == 2'd0) && ((r100 != 7'd0) || (q_r[1:0] == 2'd0));
    prod7   = 25'(sum_r) * 25'(RECIP_7);
    rem7    = sum_r - 12'(12'(q7_r) * WEEK_DAYS);
  end

  always_comb begin
    month_nxt = month_r;
    yp_nxt    = yp_r;
    q_nxt     = q_r;
    k_nxt     = k_r;
    j_nxt     = j_r;
    len_nxt   = len_r;
    sum_nxt   = sum_r;
    q7_nxt    = q7_r;
    day_nxt   = day_r;
    wd_nxt    = wd_r;
    if (cmd.load) begin
      month_nxt = in_month;
      yp_nxt    = 16'(in_year) + CYCLE_YEARS;
    end
    if (cmd.div) begin
      q_nxt = prod100[27:19];
    end
    if (cmd.rem) begin
      // Jan/Feb belong to the year before
      if (early) begin
        k_nxt = (r100 == 7'd0) ? 7'd99 : r100 - 7'd1;
        j_nxt = (r100 == 7'd0) ? q_r - 9'd1 : q_r;
      end else begin
        k_nxt = r100;
        j_nxt = q_r;
      end
      len_nxt = month_len(month_r, leap);
    end
    if (cmd.sum) begin
      sum_nxt = 12'd1 + 12'(month_offset(month_r)) + 12'(k_r) + 12'(k_r >> 2)
              + 12'(j_r >> 2) + 12'(12'(j_r) * 12'd5);
    end
    if (cmd.mod) begin
      q7_nxt = prod7[24:15];
    end
    if (cmd.wd) begin
      wd_nxt  = rem7[WD_W-1:0];
      day_nxt = 5'd1;
    end
    if (cmd.step) begin
      day_nxt = day_r + 5'd1;
      wd_nxt  = (wd_r == WD_FRIDAY) ? WD_SATURDAY : wd_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    month_r <= month_nxt;
    yp_r    <= yp_nxt;
    q_r     <= q_nxt;
    k_r     <= k_nxt;
    j_r     <= j_nxt;
    len_r   <= len_nxt;
    sum_r   <= sum_nxt;
    q7_r    <= q7_nxt;
    day_r   <= day_nxt;
    wd_r    <= wd_nxt;
  end

  assign sts.month_ok = (in_month >= MON_JAN) && (in_month <= MON_DEC);
  assign sts.last_day = (day_r == len_r);

  assign out_day_number     = day_r;
  assign out_weekday_column = wd_r;
  assign out_row_end        = (wd_r == WD_FRIDAY);
  assign out_last           = (day_r == len_r);

endmodule

// ----- hdl/mcds_checker.sv -----
// Port-level checks on the month calendar sequencer, bound to the top level.
// Depends on mcds_pkg and month_calendar_day_sequencer_top.
`timescale 1ns / 1ps

module mcds_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [mcds_pkg::DAY_W-1:0]    out_day_number,
  input logic [mcds_pkg::WD_W-1:0]     out_weekday_column,
  input logic                          out_row_end,
  input logic                          out_last
);
  import mcds_pkg::*;

  // stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_day_number)
      && $stable(out_weekday_column) && $stable(out_last))
    else $error("stalled output item changed");

  // one month at a time
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while days pending");

  // setup takes cycles before the first day
  a_setup_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid)
    else $error("output valid right after input accept");

  // days run back to back, counting up, weekday advancing
  a_day_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid
      && (out_day_number == $past(out_day_number) + 5'd1)
      && (out_weekday_column == (($past(out_weekday_column) == WD_FRIDAY)
                                 ? WD_SATURDAY : $past(out_weekday_column) + 3'd1)))
    else $error("day sequence broken");

  a_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_row_end == (out_weekday_column == WD_FRIDAY)))
    else $error("row end flag disagrees with weekday");

endmodule

bind month_calendar_day_sequencer_top mcds_checker u_mcds_checker (.*);
